// ===== hw/rtl/ppd_pkg.sv =====
// Package for the period peak detector: register indexes, register widths,
// reset values and fixed-point constants. No dependencies.
package ppd_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_RATIO_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PEAK_FLOOR      = 2'd1;

  // Ratio threshold: unsigned Q4.8
  localparam int RATIO_W    = 12;
  localparam int RATIO_FRAC = 8;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 12'd1971;  // 7.7 rounded down

  // Peak floor: signed 16 bit
  localparam int FLOOR_W = 16;
  localparam logic signed [FLOOR_W-1:0] FLOOR_RESET = 16'sd35;

  // Period counter width and window fill
  localparam int PERIOD_W = 16;
  localparam logic [1:0] FILL_DONE = 2'd2;

endpackage

// ===== hw/rtl/period_peak_detector.sv =====
// Period peak detector top level: input register, single-pass peak/period
// logic and result register. Depends on ppd_pkg.

// Takes one signed sample per cycle (valid/ready) and reports one item per
// detected period: the index and value of the period's maximum and the period
// number. The middle of a three-sample window is tested as a local minimum
// and maximum; a period ends when |max| * 256 >= ratio_threshold * |min|
// (ratio in Q4.8). A sample with last_sample set runs a final check of the
// pending peak against that sample and then restarts the stream. Throughput
// is one sample per cycle while results are taken; a result held by a low
// out_ready stalls the input register, and in_ready follows out_ready in the
// same cycle. A sample accepted into the input register is processed once the
// result register is free or being taken; its result, if any, is valid from
// the next edge. The path that sets the clock is the tracker update followed by
// two parallel 12 x SAMPLE_WIDTH multiply-compares. Configuration writes are
// accepted every cycle and must only be issued while the block is idle.
module period_peak_detector #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int INDEX_WIDTH  = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ppd_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [ppd_pkg::CFG_DATA_W-1:0]        cfg_data,
  // sample input
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample,
  input  logic                                  last_sample,
  // peak output
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [INDEX_WIDTH-1:0]                peak_index,
  output logic signed [SAMPLE_WIDTH-1:0]        peak_value,
  output logic [ppd_pkg::PERIOD_W-1:0]          period_number,
  output logic                                  from_end_check
);

  localparam int CMP_W  = (SAMPLE_WIDTH > ppd_pkg::FLOOR_W) ? SAMPLE_WIDTH
                                                            : ppd_pkg::FLOOR_W;
  localparam int PROD_W = SAMPLE_WIDTH + ppd_pkg::RATIO_W;

  // |num| * 2^frac >= thr * |den| on magnitudes
  function automatic logic ratio_ge(
    input logic [SAMPLE_WIDTH-1:0]       num_mag,
    input logic [SAMPLE_WIDTH-1:0]       den_mag,
    input logic [ppd_pkg::RATIO_W-1:0]   thr
  );
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;
    lhs = PROD_W'(num_mag) << ppd_pkg::RATIO_FRAC;
    rhs = PROD_W'(thr) * PROD_W'(den_mag);
    return lhs >= rhs;
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] magnitude(
    input logic signed [SAMPLE_WIDTH-1:0] v
  );
    return v[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-v) : SAMPLE_WIDTH'(v);
  endfunction

  // configuration registers
  logic [ppd_pkg::RATIO_W-1:0]        ratio_threshold;
  logic signed [ppd_pkg::FLOOR_W-1:0] peak_floor;

  // input register
  logic                               in_full;
  logic signed [SAMPLE_WIDTH-1:0]     sample_q;
  logic                               last_q;

  // stream state
  logic signed [SAMPLE_WIDTH-1:0]     older_sample, older_sample_next;
  logic signed [SAMPLE_WIDTH-1:0]     middle_sample, middle_sample_next;
  logic [1:0]                         fill_count, fill_count_next;
  logic signed [SAMPLE_WIDTH-1:0]     tracked_min, tracked_min_next;
  logic                               min_valid, min_valid_next;
  logic signed [SAMPLE_WIDTH-1:0]     tracked_max, tracked_max_next;
  logic                               max_valid, max_valid_next;
  logic [INDEX_WIDTH-1:0]             max_position, max_position_next;
  logic [INDEX_WIDTH-1:0]             sample_count, sample_count_next;
  logic [ppd_pkg::PERIOD_W-1:0]       period_count, period_count_next;

  // datapath intermediates
  logic                               proc;
  logic                               fill_done;
  logic [INDEX_WIDTH-1:0]             count_inc;
  logic [INDEX_WIDTH-1:0]             mid_index;
  logic signed [CMP_W-1:0]            floor_cmp;
  logic signed [CMP_W-1:0]            mid_cmp;
  logic signed [CMP_W-1:0]            max1_cmp;
  logic                               is_min, is_max;
  logic signed [SAMPLE_WIDTH-1:0]     min1, max1;
  logic                               minv1, minv2, maxv1;
  logic [INDEX_WIDTH-1:0]             pos1;
  logic [SAMPLE_WIDTH-1:0]            mag_max, mag_min, mag_x;
  logic                               main_hit, end_hit, emit_fire;

  assign cfg_ready = 1'b1;
  assign proc      = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || proc;

  // saturating index and the index of the middle sample
  assign count_inc = (sample_count == '1) ? sample_count : sample_count + 1'b1;
  assign mid_index = sample_count - 1'b1;
  assign fill_done = (fill_count == ppd_pkg::FILL_DONE);

  // min/max trackers on the middle of the window
  always_comb begin
    floor_cmp = CMP_W'(peak_floor);
    mid_cmp   = CMP_W'(middle_sample);
    is_min = (older_sample >= middle_sample) && (middle_sample <= sample_q) &&
             (!min_valid || (middle_sample < tracked_min));
    min1   = is_min ? middle_sample : tracked_min;
    minv1  = min_valid || is_min;
    is_max = (older_sample <= middle_sample) && (middle_sample >= sample_q) &&
             (!max_valid || (middle_sample > tracked_max)) && (mid_cmp > floor_cmp);
    max1   = is_max ? middle_sample : tracked_max;
    maxv1  = max_valid || is_max;
    minv2  = is_max ? 1'b0 : minv1;
    pos1   = is_max ? mid_index : max_position;
    max1_cmp = CMP_W'(max1);
  end

  // period end and end-of-stream checks
  always_comb begin
    mag_max = magnitude(max1);
    mag_min = magnitude(min1);
    mag_x   = magnitude(sample_q);
    if (minv2) begin
      main_hit = maxv1 && !((max1 == '0) && (min1 == '0)) &&
                 ratio_ge(mag_max, mag_min, ratio_threshold);
    end else begin
      main_hit = maxv1 && (ratio_threshold == '0);
    end
    // ratio against min is known not reached when main_hit is low
    end_hit = last_q && !main_hit && maxv1 && (max1_cmp > floor_cmp) &&
              !(minv2 && (max1 == '0) && (min1 == '0)) &&
              !((max1 == '0) && (sample_q == '0)) &&
              ratio_ge(mag_max, mag_x, ratio_threshold);
    emit_fire = proc && fill_done && (main_hit || end_hit);
  end

  // next stream state
  always_comb begin
    older_sample_next  = older_sample;
    middle_sample_next = middle_sample;
    fill_count_next    = fill_count;
    tracked_min_next   = tracked_min;
    min_valid_next     = min_valid;
    tracked_max_next   = tracked_max;
    max_valid_next     = max_valid;
    max_position_next  = max_position;
    sample_count_next  = sample_count;
    period_count_next  = period_count;
    if (proc) begin
      older_sample_next  = middle_sample;
      middle_sample_next = sample_q;
      sample_count_next  = count_inc;
      if (!fill_done) begin
        fill_count_next = fill_count + 1'b1;
      end else begin
        tracked_min_next  = min1;
        tracked_max_next  = max1;
        max_position_next = pos1;
        if (main_hit) begin
          max_valid_next = 1'b0;
          min_valid_next = 1'b0;
        end else begin
          max_valid_next = maxv1;
          min_valid_next = minv2;
        end
        if (emit_fire && (period_count != '1)) begin
          period_count_next = period_count + 1'b1;
        end
      end
      // end of stream: back to the reset state
      if (last_q) begin
        older_sample_next  = '0;
        middle_sample_next = '0;
        fill_count_next    = '0;
        tracked_min_next   = '0;
        min_valid_next     = 1'b0;
        tracked_max_next   = '0;
        max_valid_next     = 1'b0;
        max_position_next  = '0;
        sample_count_next  = '0;
        period_count_next  = '0;
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_threshold <= ppd_pkg::RATIO_RESET;
      peak_floor      <= ppd_pkg::FLOOR_RESET;
      in_full         <= 1'b0;
      out_valid       <= 1'b0;
      older_sample    <= '0;
      middle_sample   <= '0;
      fill_count      <= '0;
      tracked_min     <= '0;
      min_valid       <= 1'b0;
      tracked_max     <= '0;
      max_valid       <= 1'b0;
      max_position    <= '0;
      sample_count    <= '0;
      period_count    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ppd_pkg::CFG_RATIO_THRESHOLD: ratio_threshold <= cfg_data[ppd_pkg::RATIO_W-1:0];
          ppd_pkg::CFG_PEAK_FLOOR:      peak_floor      <= cfg_data[ppd_pkg::FLOOR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (proc) begin
        in_full <= 1'b0;
      end
      if (proc) begin
        out_valid <= emit_fire;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      older_sample  <= older_sample_next;
      middle_sample <= middle_sample_next;
      fill_count    <= fill_count_next;
      tracked_min   <= tracked_min_next;
      min_valid     <= min_valid_next;
      tracked_max   <= tracked_max_next;
      max_valid     <= max_valid_next;
      max_position  <= max_position_next;
      sample_count  <= sample_count_next;
      period_count  <= period_count_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_q <= sample;
      last_q   <= last_sample;
    end
    if (emit_fire) begin
      peak_index     <= pos1;
      peak_value     <= max1;
      period_number  <= period_count;
      from_end_check <= !main_hit;
    end
  end

`ifndef SYNTH
  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !proc)
    else $error("result register overwritten while stalled");

  // a new result only comes from a processed item
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(proc))
    else $error("result appeared without a processed item");

  // the window counter never passes full
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_count != 2'd3)
    else $error("fill count out of range");

  // the last item of a stream leaves the stream state cleared
  a_stream_restart: assert property (@(posedge clk) disable iff (rst)
    proc && last_q |=> (fill_count == '0) && (sample_count == '0) &&
                       !max_valid && !min_valid && (period_count == '0))
    else $error("stream state not cleared after last item");

  // the input register is freed whenever it takes a new item while full
  a_input_flow: assert property (@(posedge clk) disable iff (rst)
    in_full && in_valid && in_ready |-> proc)
    else $error("input register overwritten before processing");
`endif

endmodule

// ===== tb/sv/period_peak_detector_test.sv =====
// Self-checking testbench for period_peak_detector: streams of signed samples
// go in, each reported peak is checked against an in-bench predictor.
// Depends on ppd_pkg and the period_peak_detector RTL.
`timescale 1ns / 100ps

module period_peak_detector_test;

  localparam int SW = 16;
  localparam int IW = 24;
  localparam int RW = ppd_pkg::RATIO_W;
  localparam int DW = ppd_pkg::CFG_DATA_W;

  typedef struct {
    logic [IW-1:0]                index;
    logic signed [SW-1:0]         value;
    logic [ppd_pkg::PERIOD_W-1:0] period;
    logic                         from_end;
  } peak_t;

  typedef logic signed [SW-1:0] sample_q_t[$];

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [ppd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [DW-1:0]                   cfg_data = '0;

  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic signed [SW-1:0]   sample = '0;
  logic                   last_sample = 1'b0;

  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [IW-1:0]                peak_index;
  logic signed [SW-1:0]         peak_value;
  logic [ppd_pkg::PERIOD_W-1:0] period_number;
  logic                         from_end_check;

  // Predictor state: registers and per-stream trackers
  logic [RW-1:0]                ratio_cfg;
  logic signed [SW-1:0]         floor_cfg;
  logic signed [SW-1:0]         win_older, win_middle;
  int                           fill;
  logic signed [SW-1:0]         low_track, high_track;
  bit                           low_ok, high_ok;
  logic [IW-1:0]                peak_pos, next_index;
  logic [ppd_pkg::PERIOD_W-1:0] periods_done;

  peak_t expected_peaks[$];
  int    mismatches = 0;
  int    samples_accepted = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;

  period_peak_detector #(
    .SAMPLE_WIDTH(SW),
    .INDEX_WIDTH (IW)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample        (sample),
    .last_sample   (last_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .peak_index    (peak_index),
    .peak_value    (peak_value),
    .period_number (period_number),
    .from_end_check(from_end_check)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_stream();
    win_older = '0;
    win_middle = '0;
    fill = 0;
    low_track = '0;
    low_ok = 1'b0;
    high_track = '0;
    high_ok = 1'b0;
    peak_pos = '0;
    next_index = '0;
    periods_done = '0;
  endfunction

  // |num| / |den| >= ratio, as an exact multiply-compare in Q4.8
  function automatic bit ratio_met(input longint num, input longint den, input bit den_ok);
    longint num_mag, den_mag;
    num_mag = (num < 0) ? -num : num;
    den_mag = (den < 0) ? -den : den;
    if (!den_ok) return ratio_cfg == '0;
    if (num == 0 && den == 0) return 1'b0;  // 0/0 is unordered
    return (num_mag * 256) >= (longint'(ratio_cfg) * den_mag);
  endfunction

  function automatic void record_peak(input bit at_end);
    peak_t p;
    p.index = peak_pos;
    p.value = high_track;
    p.period = periods_done;
    p.from_end = at_end;
    expected_peaks.push_back(p);
    if (periods_done != '1) periods_done++;
  endfunction

  function automatic void predict_sample(input logic signed [SW-1:0] x, input logic is_last);
    logic [IW-1:0]        mid_index;
    logic signed [SW-1:0] a, b;
    bit                   emitted;
    emitted = 1'b0;
    // window still filling
    if (fill < 2) begin
      win_older = win_middle;
      win_middle = x;
      fill++;
      if (next_index != '1) next_index++;
      if (is_last) clear_stream();
      return;
    end
    mid_index = next_index - 1'b1;
    a = win_older;
    b = win_middle;
    // minimum test first, then maximum
    if (a >= b && b <= x && (!low_ok || b < low_track)) begin
      low_track = b;
      low_ok = 1'b1;
    end
    if (a <= b && b >= x && (!high_ok || b > high_track) && b > floor_cfg) begin
      high_track = b;
      high_ok = 1'b1;
      low_ok = 1'b0;
      peak_pos = mid_index;
    end
    if (high_ok && ratio_met(high_track, low_track, low_ok)) begin
      record_peak(1'b0);
      emitted = 1'b1;
      high_ok = 1'b0;
      low_ok = 1'b0;
    end
    win_older = b;
    win_middle = x;
    if (next_index != '1) next_index++;
    // end-of-stream check against the last sample itself
    if (is_last) begin
      if (!emitted && high_ok && high_track > floor_cfg &&
          !ratio_met(high_track, low_track, low_ok) &&
          !(low_ok && high_track == 0 && low_track == 0) &&
          ratio_met(high_track, x, 1'b1))
        record_peak(1'b1);
      clear_stream();
    end
  endfunction

  // ------------------------------------------------------------------ checker

  always @(posedge clk) begin : check_peaks
    peak_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_peaks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected peak: index %0d value %0d period %0d end %0b",
                   peak_index, peak_value, period_number, from_end_check);
      end else begin
        want = expected_peaks.pop_front();
        if (peak_index !== want.index || peak_value !== want.value ||
            period_number !== want.period || from_end_check !== want.from_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("peak mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                     want.index, want.value, want.period, want.from_end,
                     peak_index, peak_value, period_number, from_end_check);
        end
      end
    end
  end

  // ------------------------------------------------------------------ drivers

  task automatic send_sample(input logic signed [SW-1:0] value, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= value;
    last_sample <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_sample(value, is_last);
    samples_accepted++;
  endtask

  task automatic send_wave(input sample_q_t wave, input bit closes);
    foreach (wave[i]) send_sample(wave[i], closes && (i == wave.size() - 1));
  endtask

  // Let all expected peaks arrive, then the pipeline empty out
  task automatic wait_for_peaks();
    int waited;
    peak_t lost;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_peaks.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    while (expected_peaks.size() != 0) begin
      lost = expected_peaks.pop_front();
      mismatches++;
      if (mismatches <= 10)
        $display("missing peak: index %0d value %0d period %0d end %0b",
                 lost.index, lost.value, lost.period, lost.from_end);
    end
  endtask

  task automatic write_register(input logic [ppd_pkg::CFG_INDEX_W-1:0] index,
                                input logic [DW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (index == ppd_pkg::CFG_RATIO_THRESHOLD) ratio_cfg = data[RW-1:0];
    else if (index == ppd_pkg::CFG_PEAK_FLOOR) floor_cfg = data;
  endtask

  task automatic pick_setting();
    logic [RW-1:0]        ratio;
    logic signed [SW-1:0] floor_val;
    int                   f;
    case ($urandom_range(5))
      0:       ratio = '0;
      1:       ratio = '1;
      default: ratio = RW'($urandom_range(128, 2600));
    endcase
    f = $urandom_range(0, 400) - 100;
    case ($urandom_range(7))
      0:       floor_val = 16'sh8000;
      1:       floor_val = 16'sh7fff;
      default: floor_val = f[SW-1:0];
    endcase
    write_register(ppd_pkg::CFG_RATIO_THRESHOLD, DW'(ratio));
    write_register(ppd_pkg::CFG_PEAK_FLOOR, floor_val);
  endtask

  // One stream: mostly peak/valley shapes, some noise, some flat runs
  task automatic send_random_stream();
    sample_q_t            wave;
    int                   len, kind, top, depth, v, rnd;
    logic signed [SW-1:0] level;
    kind = $urandom_range(99);
    len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
    while (wave.size() < len) begin
      if (len <= 3 || (kind >= 70 && kind < 90)) begin
        rnd = $urandom();
        wave.push_back(rnd[SW-1:0]);
      end else if (kind < 70) begin
        // a peak followed by a short valley, no larger in magnitude than the peak
        top = $urandom_range(0, 32767) >> $urandom_range(0, 10);
        wave.push_back(top[SW-1:0]);
        repeat ($urandom_range(1, 3)) begin
          depth = top >> $urandom_range(0, 8);
          v = $urandom_range(0, depth);
          if ($urandom_range(1)) v = -v;
          wave.push_back(v[SW-1:0]);
        end
      end else begin
        case ($urandom_range(4))
          0:       level = 16'sh8000;
          1:       level = 16'sh7fff;
          2:       level = '0;
          3:       level = floor_cfg;
          default: level = floor_cfg + 1'b1;
        endcase
        repeat ($urandom_range(1, 4)) wave.push_back(level);
      end
    end
    send_wave(wave, $urandom_range(9) != 0);
  endtask

  // -------------------------------------------------------------------- tests

  // Reset settings: window fill, extremes, zero minimum, flat run, final check
  task automatic test_stream_shapes();
    sample_q_t wave;
    wave = {16'sd100, 16'sd200};
    send_wave(wave, 1'b1);
    wave = {16'sd0, 16'sh7fff, 16'sd0, 16'sd5, 16'sh8000, 16'sd40, 16'sh8000};
    send_wave(wave, 1'b1);
    wave = {16'sd50, 16'sd50, 16'sd50, 16'sd50};
    send_wave(wave, 1'b1);
    wave = {16'sd0, 16'sd200, 16'sd100, 16'sd20};
    send_wave(wave, 1'b1);
    wave = {16'sd0, 16'sd300, 16'sd100, 16'sd0};
    send_wave(wave, 1'b1);
    wait_for_peaks();
  endtask

  // Zero maximum over zero minimum never ends a period, nor passes the final check
  task automatic test_unordered_ratio();
    sample_q_t wave;
    write_register(ppd_pkg::CFG_PEAK_FLOOR, -16'sd5);
    wave = {-16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd2};
    send_wave(wave, 1'b1);
    wait_for_peaks();
  endtask

  // Zero ratio: every held maximum ends a period at once
  task automatic test_zero_ratio();
    int i;
    write_register(ppd_pkg::CFG_RATIO_THRESHOLD, '0);
    for (i = 0; i < 64; i++)
      send_sample((i % 2) ? 16'sd1000 : 16'sd0, i == 63);
    wait_for_peaks();
  endtask

  task automatic test_random_phases();
    int phase, target;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      pick_setting();
      target = samples_accepted + 350;
      while (samples_accepted < target) begin
        // now and then the sender holds off until every peak is in, then picks new settings
        if ($urandom_range(3) == 0) begin
          wait_for_peaks();
          pick_setting();
        end
        send_random_stream();
      end
      wait_for_peaks();
    end
  endtask

  initial begin
    ratio_cfg = ppd_pkg::RATIO_RESET;
    floor_cfg = ppd_pkg::FLOOR_RESET;
    clear_stream();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_stream_shapes();
    test_unordered_ratio();
    test_zero_ratio();
    test_random_phases();
    wait_for_peaks();
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Run limit
  initial begin
    #15_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== period_peak_detector.f =====
hw/rtl/ppd_pkg.sv
hw/rtl/period_peak_detector.sv
tb/sv/period_peak_detector_test.sv
